/* src/iwt_pkg.sv */
// iwt_pkg: shared types, token codes and helper functions for integer_to_word_tokens.
// Used by iwt_front, iwt_queue, iwt_back and the top level; depends on nothing.
package iwt_pkg;

    localparam int VALUE_W        = 31;
    localparam int WORD_W         = 5;
    localparam int BIN_W          = 32;           // value padded to a multiple of 4 bits
    localparam int DIGITS         = 10;
    localparam int BCD_W          = 4 * DIGITS;
    localparam int BITS_PER_STAGE = 4;
    localparam int NUM_STAGES     = BIN_W / BITS_PER_STAGE;
    localparam int NUM_GROUPS     = 4;            // billion, million, thousand, units
    localparam int SLOTS_PER_GRP  = 5;            // digit, Hundred, tens/teen, unit, scale
    localparam int NUM_SLOTS      = NUM_GROUPS * SLOTS_PER_GRP;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [WORD_W-1:0] TOK_ZERO      = 5'd0;
    localparam logic [WORD_W-1:0] TOK_TEN       = 5'd10;
    localparam logic [WORD_W-1:0] TOK_TENS_BASE = 5'd18;
    localparam logic [WORD_W-1:0] TOK_HUNDRED   = 5'd28;
    localparam logic [WORD_W-1:0] TOK_BILLION   = 5'd31;

    // slot positions inside a group
    localparam int SLOT_DIGIT   = 0;
    localparam int SLOT_HUNDRED = 1;
    localparam int SLOT_TENS    = 2;
    localparam int SLOT_UNIT    = 3;
    localparam int SLOT_SCALE   = 4;
    localparam int UNITS_GROUP  = NUM_GROUPS - 1;

    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] bin;
    } dd_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]             mask;
        logic [NUM_SLOTS-1:0][WORD_W-1:0] tok;
    } tok_entry_t;

    // one double-dabble step: adjust every digit, then shift in one binary bit
    function automatic logic [BCD_W-1:0] dd_shift(input logic [BCD_W-1:0] bcd, input logic b);
        logic [BCD_W-1:0] adj;
        logic [3:0]       d;
        for (int i = 0; i < DIGITS; i++) begin
            d = bcd[4*i +: 4];
            adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    function automatic dd_t dd_stage(input dd_t s);
        dd_t r;
        r = s;
        for (int i = 0; i < BITS_PER_STAGE; i++) begin
            r.bcd = dd_shift(r.bcd, r.bin[BIN_W-1]);
            r.bin = {r.bin[BIN_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // lay out every possible token of a number in fixed slots with a mask
    function automatic tok_entry_t classify(input logic [BCD_W-1:0] bcd);
        tok_entry_t       e;
        logic [47:0]      ext;
        logic [3:0]       h, t, u;
        int               base, s;
        ext = {{(48-BCD_W){1'b0}}, bcd};
        e   = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            base = 3 * (UNITS_GROUP - g);
            s    = g * SLOTS_PER_GRP;
            u = ext[4*base +: 4];
            if (g == 0) begin
                t = 4'd0;
                h = 4'd0;
            end else begin
                t = ext[4*(base+1) +: 4];
                h = ext[4*(base+2) +: 4];
            end
            e.tok[s+SLOT_DIGIT]    = {1'b0, h};
            e.mask[s+SLOT_DIGIT]   = (h != 4'd0);
            e.tok[s+SLOT_HUNDRED]  = TOK_HUNDRED;
            e.mask[s+SLOT_HUNDRED] = (h != 4'd0);
            if (t >= 4'd2) begin
                e.tok[s+SLOT_TENS] = TOK_TENS_BASE + {1'b0, t};
                e.mask[s+SLOT_UNIT] = (u != 4'd0);
            end else if (t == 4'd1) begin
                e.tok[s+SLOT_TENS] = TOK_TEN + {1'b0, u};
            end else begin
                e.tok[s+SLOT_TENS] = {1'b0, u};
            end
            e.mask[s+SLOT_TENS] = (t != 4'd0) || (u != 4'd0);
            e.tok[s+SLOT_UNIT]  = {1'b0, u};
            e.tok[s+SLOT_SCALE] = TOK_BILLION - WORD_W'(g);
            e.mask[s+SLOT_SCALE] = (g != UNITS_GROUP) &&
                                   ((h != 4'd0) || (t != 4'd0) || (u != 4'd0));
        end
        if (bcd == '0) begin
            e.tok[UNITS_GROUP*SLOTS_PER_GRP+SLOT_TENS]  = TOK_ZERO;
            e.mask[UNITS_GROUP*SLOTS_PER_GRP+SLOT_TENS] = 1'b1;
        end
        return e;
    endfunction

endpackage

/* src/integer_to_word_tokens.sv */
// integer_to_word_tokens: spells a 31-bit value as English word tokens.
// Top level; instantiates iwt_front, iwt_queue and iwt_back, uses iwt_pkg.
//
//   channel | ports                      | word
//   --------+----------------------------+------------------------------------
//   input   | s_valid s_ready s_value    | one value, 0..2^31-1
//   result  | m_valid m_ready m_word     | one token, m_last on the final one
//           | m_last                     |
//
// Flow: the front is an 8-stage decimal conversion (4 bits per stage) and
// takes a new value every cycle unless a full queue holds it; the back sends
// one token per cycle while m_ready allows, and a number has 1 to 16 tokens.
// Reset (aresetn low, synchronous) empties the pipe, queue and output register.
// Either side may stall: a full queue holds the front, m_ready low holds the back.
module integer_to_word_tokens #(
    parameter int QUEUE_DEPTH = iwt_pkg::QUEUE_DEPTH   // classified numbers buffered, >= 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [iwt_pkg::VALUE_W-1:0]    s_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [iwt_pkg::WORD_W-1:0]     m_word,
    output logic                           m_last
);

    // front -> queue
    logic                 push, push_ready;
    iwt_pkg::tok_entry_t  push_entry;
    // queue -> back
    logic                 q_valid, q_pop;
    iwt_pkg::tok_entry_t  q_entry;

    // conversion pipe plus slot layout of all candidate tokens
    iwt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .push       (push),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // decouples the conversion pipe from the token walk
    iwt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (push),
        .wr_ready (push_ready),
        .wr_entry (push_entry),
        .rd_valid (q_valid),
        .rd_en    (q_pop),
        .rd_entry (q_entry)
    );

    // emits the masked slots in order, next number loaded with the final token
    iwt_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_entry (q_entry),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word),
        .m_last  (m_last)
    );

endmodule

/* src/iwt_front.sv */
// iwt_front: accepts values, converts them to decimal in a stall-able pipeline
// and lays out the tokens per slot. Depends on iwt_pkg.
module iwt_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [iwt_pkg::VALUE_W-1:0]      s_value,
    output logic                             push,
    input  logic                             push_ready,
    output iwt_pkg::tok_entry_t              push_entry
);

    localparam int NS = iwt_pkg::NUM_STAGES;

    logic [NS-1:0]   vld_reg, vld_next;
    iwt_pkg::dd_t    stg_reg [NS];
    iwt_pkg::dd_t    stg_next[NS];
    logic            advance;

    // whole pipe moves unless the finished value cannot enter the queue
    assign advance = !(vld_reg[NS-1] && !push_ready);
    assign s_ready = advance;
    assign push    = vld_reg[NS-1] && push_ready;
    assign push_entry = iwt_pkg::classify(stg_reg[NS-1].bcd);

    always_comb begin
        iwt_pkg::dd_t src;
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                src.bcd = '0;
                src.bin = {{(iwt_pkg::BIN_W-iwt_pkg::VALUE_W){1'b0}}, s_value};
            end else begin
                src = stg_reg[k-1];
            end
            stg_next[k] = advance ? iwt_pkg::dd_stage(src) : stg_reg[k];
            if (!advance) begin
                vld_next[k] = vld_reg[k];
            end else if (k == 0) begin
                vld_next[k] = s_valid;
            end else begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NS; k++) begin
            stg_reg[k] <= stg_next[k];
        end
    end

endmodule

/* src/iwt_queue.sv */
// iwt_queue: small FIFO of classified token sets between front and back.
// Depends on iwt_pkg.
module iwt_queue #(
    parameter int DEPTH = iwt_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    output logic                 wr_ready,
    input  iwt_pkg::tok_entry_t  wr_entry,
    output logic                 rd_valid,
    input  logic                 rd_en,
    output iwt_pkg::tok_entry_t  rd_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    iwt_pkg::tok_entry_t store [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    assign wr_ready = (cnt_reg != CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_entry = store[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

/* src/iwt_back.sv */
// iwt_back: walks the token slots of one number, one word per cycle unless m_ready
// holds it, into a registered output. Depends on iwt_pkg.
module iwt_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  iwt_pkg::tok_entry_t           q_entry,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [iwt_pkg::WORD_W-1:0]    m_word,
    output logic                          m_last
);

    localparam int NSL = iwt_pkg::NUM_SLOTS;

    logic [NSL-1:0]                          mask_reg, mask_next;
    logic [NSL-1:0][iwt_pkg::WORD_W-1:0]     tok_reg, tok_next;
    logic                                    mvalid_reg, mvalid_next;
    logic [iwt_pkg::WORD_W-1:0]              word_reg, word_next;
    logic                                    last_reg, last_next;
    logic [NSL-1:0]                          pick, rest, mask_after;
    logic [iwt_pkg::WORD_W-1:0]              pick_word;
    logic                                    out_free, emit;

    assign out_free = !mvalid_reg || m_ready;
    assign pick     = mask_reg & (~mask_reg + NSL'(1));   // lowest pending slot
    assign rest     = mask_reg & ~pick;
    assign emit     = out_free && (mask_reg != '0);
    assign mask_after = emit ? rest : mask_reg;
    assign q_pop    = (mask_after == '0) && q_valid;

    always_comb begin
        pick_word = '0;
        for (int i = 0; i < NSL; i++) begin
            pick_word = pick_word | (pick[i] ? tok_reg[i] : '0);
        end
    end

    always_comb begin
        mask_next   = q_pop ? q_entry.mask : mask_after;
        tok_next    = q_pop ? q_entry.tok  : tok_reg;
        mvalid_next = emit ? 1'b1 : (m_ready ? 1'b0 : mvalid_reg);
        word_next   = emit ? pick_word : word_reg;
        last_next   = emit ? (rest == '0) : last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            mask_reg   <= mask_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg  <= tok_next;
        word_reg <= word_next;
        last_reg <= last_next;
    end

    assign m_valid = mvalid_reg;
    assign m_word  = word_reg;
    assign m_last  = last_reg;

endmodule
